### rtl/synth_voice_allocator_defines.svh
// Assertion macros for the voice allocator.
`ifndef SYNTH_VOICE_ALLOCATOR_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define SVA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("voice allocator assertion failed");

// Next-cycle implication.
`define SVA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("voice allocator assertion failed");

`endif

### rtl/sva_pkg.sv
package sva_pkg;

    localparam int VOICE_COUNT = 8;
    localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    typedef logic [VIDX_W-1:0]      vidx_t;
    typedef logic [VOICE_COUNT-1:0] vmask_t;
    typedef logic [2:0]             op_t;
    typedef logic [1:0]             kind_t;
    typedef logic [6:0]             note_t;
    typedef logic [15:0]            ring_t;
    typedef logic [31:0]            age_t;
    typedef logic [0:0]             reg_idx_t;

    localparam op_t OP_NOTE_ON    = 3'd0;
    localparam op_t OP_NOTE_OFF   = 3'd1;
    localparam op_t OP_SET_RING   = 3'd2;
    localparam op_t OP_VOICE_DONE = 3'd3;
    localparam op_t OP_ALL_OFF    = 3'd4;

    localparam kind_t KIND_FREE   = 2'd0;
    localparam kind_t KIND_QUIET  = 2'd1;
    localparam kind_t KIND_OLDEST = 2'd2;
    localparam kind_t KIND_NONE   = 2'd3;

    localparam reg_idx_t REG_MONO_MODE = 1'b0;

endpackage

### rtl/synth_voice_allocator.sv
// Every op but note on runs from request through ST_EXEC to ST_DONE; a note on
// that finds a free voice or runs in mono mode adds ST_COMMIT, and one that
// steals also runs ST_SCAN first, one voice per cycle through a shared comparator.
// One request at a time; the next is taken once the result is on the output.
// Reset (aresetn low, synchronous): all voices free and ungated, age counter and
// mono_mode cleared, no result pending.
`include "synth_voice_allocator_defines.svh"

module synth_voice_allocator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [6:0]  s_note,
    input  logic [2:0]  s_voice,
    input  logic [15:0] s_ring_level,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_chosen_voice,
    output logic [1:0]  m_take_kind,
    output logic [7:0]  m_released_mask
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic mono_reg, mono_next;

    sva_pkg::op_t   op_reg, op_next;
    sva_pkg::note_t note_in_reg, note_in_next;
    logic [2:0]     voice_in_reg, voice_in_next;
    sva_pkg::ring_t ring_in_reg, ring_in_next;

    sva_pkg::vmask_t voice_used_reg, voice_used_next;
    sva_pkg::vmask_t voice_gate_reg, voice_gate_next;
    sva_pkg::note_t  voice_note_reg [sva_pkg::VOICE_COUNT];
    sva_pkg::note_t  voice_note_next[sva_pkg::VOICE_COUNT];
    sva_pkg::age_t   voice_age_reg  [sva_pkg::VOICE_COUNT];
    sva_pkg::age_t   voice_age_next [sva_pkg::VOICE_COUNT];
    sva_pkg::ring_t  voice_ring_reg [sva_pkg::VOICE_COUNT];
    sva_pkg::ring_t  voice_ring_next[sva_pkg::VOICE_COUNT];
    sva_pkg::age_t   age_count_reg, age_count_next;

    sva_pkg::vidx_t  scan_idx_reg, scan_idx_next;
    sva_pkg::vidx_t  pick_idx_reg, pick_idx_next;
    sva_pkg::age_t   best_key_reg, best_key_next;
    logic            found_reg, found_next;
    logic            use_ring_reg, use_ring_next;
    sva_pkg::kind_t  kind_reg, kind_next;
    sva_pkg::vmask_t mask_reg, mask_next;

    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_chosen_voice_reg, m_chosen_voice_next;
    sva_pkg::kind_t m_take_kind_reg, m_take_kind_next;
    logic [7:0]     m_released_mask_reg, m_released_mask_next;

    logic           cfg_write;
    logic           any_unused;
    logic           any_released;
    sva_pkg::vidx_t first_unused;
    sva_pkg::vidx_t voice_idx;
    logic           voice_ok;
    sva_pkg::age_t  scan_key;
    logic           scan_elig;
    logic           scan_last;

    function automatic logic reg_idx_t_eq(input sva_pkg::reg_idx_t a);
        return a == sva_pkg::REG_MONO_MODE;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (reg_idx_t_eq(paddr[2])) ? {31'b0, mono_reg} : 32'b0;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_chosen_voice  = m_chosen_voice_reg;
    assign m_take_kind     = m_take_kind_reg;
    assign m_released_mask = m_released_mask_reg;

    assign any_unused   = ~&voice_used_reg;
    assign any_released = ~&voice_gate_reg;
    assign voice_idx    = sva_pkg::vidx_t'(32'(voice_in_reg));
    assign voice_ok     = 32'(voice_in_reg) < 32'(sva_pkg::VOICE_COUNT);
    assign scan_key     = use_ring_reg ? sva_pkg::age_t'(voice_ring_reg[scan_idx_reg])
                                       : voice_age_reg[scan_idx_reg];
    assign scan_elig    = !use_ring_reg || !voice_gate_reg[scan_idx_reg];
    assign scan_last    = (scan_idx_reg == sva_pkg::vidx_t'(sva_pkg::VOICE_COUNT - 1));

    always_comb begin
        first_unused = '0;
        for (int i = sva_pkg::VOICE_COUNT - 1; i >= 0; i--) begin
            if (!voice_used_reg[i]) begin
                first_unused = sva_pkg::vidx_t'(i);
            end
        end
    end

    always_comb begin
        state_next           = state_reg;
        mono_next            = mono_reg;
        op_next              = op_reg;
        note_in_next         = note_in_reg;
        voice_in_next        = voice_in_reg;
        ring_in_next         = ring_in_reg;
        voice_used_next      = voice_used_reg;
        voice_gate_next      = voice_gate_reg;
        voice_note_next      = voice_note_reg;
        voice_age_next       = voice_age_reg;
        voice_ring_next      = voice_ring_reg;
        age_count_next       = age_count_reg;
        scan_idx_next        = scan_idx_reg;
        pick_idx_next        = pick_idx_reg;
        best_key_next        = best_key_reg;
        found_next           = found_reg;
        use_ring_next        = use_ring_reg;
        kind_next            = kind_reg;
        mask_next            = mask_reg;
        m_valid_next         = m_valid_reg;
        m_chosen_voice_next  = m_chosen_voice_reg;
        m_take_kind_next     = m_take_kind_reg;
        m_released_mask_next = m_released_mask_reg;

        if (cfg_write && reg_idx_t_eq(paddr[2])) begin
            mono_next = pwdata[0];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_op;
                    note_in_next  = s_note;
                    voice_in_next = s_voice;
                    ring_in_next  = s_ring_level;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                kind_next     = sva_pkg::KIND_NONE;
                pick_idx_next = '0;
                mask_next     = '0;
                scan_idx_next = '0;
                found_next    = 1'b0;
                best_key_next = '0;
                state_next    = ST_DONE;
                case (op_reg)
                    sva_pkg::OP_NOTE_ON: begin
                        if (mono_reg) begin
                            state_next = ST_COMMIT;
                        end else if (any_unused) begin
                            pick_idx_next = first_unused;
                            kind_next     = sva_pkg::KIND_FREE;
                            state_next    = ST_COMMIT;
                        end else begin
                            use_ring_next = any_released;
                            kind_next     = any_released ? sva_pkg::KIND_QUIET
                                                         : sva_pkg::KIND_OLDEST;
                            state_next    = ST_SCAN;
                        end
                    end
                    sva_pkg::OP_NOTE_OFF: begin
                        for (int i = 0; i < sva_pkg::VOICE_COUNT; i++) begin
                            if (voice_used_reg[i] && voice_gate_reg[i]
                                    && voice_note_reg[i] == note_in_reg) begin
                                voice_gate_next[i] = 1'b0;
                                mask_next[i]       = 1'b1;
                            end
                        end
                    end
                    sva_pkg::OP_SET_RING: begin
                        if (voice_ok) begin
                            voice_ring_next[voice_idx] = ring_in_reg;
                        end
                    end
                    sva_pkg::OP_VOICE_DONE: begin
                        if (voice_ok) begin
                            voice_used_next[voice_idx] = 1'b0;
                            voice_gate_next[voice_idx] = 1'b0;
                        end
                    end
                    sva_pkg::OP_ALL_OFF: begin
                        for (int i = 0; i < sva_pkg::VOICE_COUNT; i++) begin
                            if (voice_used_reg[i]) begin
                                mask_next[i]       = voice_gate_reg[i];
                                voice_gate_next[i] = 1'b0;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (scan_elig && (!found_reg || scan_key < best_key_reg)) begin
                    best_key_next = scan_key;
                    pick_idx_next = scan_idx_reg;
                    found_next    = 1'b1;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                voice_used_next[pick_idx_reg] = 1'b1;
                voice_gate_next[pick_idx_reg] = 1'b1;
                voice_note_next[pick_idx_reg] = note_in_reg;
                voice_age_next[pick_idx_reg]  = age_count_reg + 32'd1;
                voice_ring_next[pick_idx_reg] = '0;
                age_count_next                = age_count_reg + 32'd1;
                state_next                    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_chosen_voice_next  = 3'(32'(pick_idx_reg));
                    m_take_kind_next     = kind_reg;
                    m_released_mask_next = 8'(32'(mask_reg));
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mono_reg       <= 1'b0;
            voice_used_reg <= '0;
            voice_gate_reg <= '0;
            voice_note_reg <= '{default: '0};
            voice_age_reg  <= '{default: '0};
            voice_ring_reg <= '{default: '0};
            age_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mono_reg       <= mono_next;
            voice_used_reg <= voice_used_next;
            voice_gate_reg <= voice_gate_next;
            voice_note_reg <= voice_note_next;
            voice_age_reg  <= voice_age_next;
            voice_ring_reg <= voice_ring_next;
            age_count_reg  <= age_count_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg              <= op_next;
        note_in_reg         <= note_in_next;
        voice_in_reg        <= voice_in_next;
        ring_in_reg         <= ring_in_next;
        scan_idx_reg        <= scan_idx_next;
        pick_idx_reg        <= pick_idx_next;
        best_key_reg        <= best_key_next;
        found_reg           <= found_next;
        use_ring_reg        <= use_ring_next;
        kind_reg            <= kind_next;
        mask_reg            <= mask_next;
        m_chosen_voice_reg  <= m_chosen_voice_next;
        m_take_kind_reg     <= m_take_kind_next;
        m_released_mask_reg <= m_released_mask_next;
    end

    `SVA_ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SVA_ASSERT_IMPL(a_take_has_no_release, aclk, aresetn,
        m_valid && m_take_kind != sva_pkg::KIND_NONE, m_released_mask == 8'd0)
    `SVA_ASSERT_IMPL(a_quiet_steal_ungated, aclk, aresetn,
        state_reg == ST_COMMIT && kind_reg == sva_pkg::KIND_QUIET,
        !voice_gate_reg[pick_idx_reg])
    `SVA_ASSERT_NEXT(a_commit_marks_voice, aclk, aresetn, state_reg == ST_COMMIT,
        voice_used_reg[pick_idx_reg] && voice_gate_reg[pick_idx_reg])

endmodule

### tb/synth_voice_allocator_tb.sv
`timescale 1ns / 100ps

module synth_voice_allocator_tb;

    localparam sva_pkg::op_t OP_RSVD_FIRST    = 3'd5;
    localparam sva_pkg::op_t OP_RSVD_LAST     = 3'd7;
    localparam int           LONG_HOLD_CYCLES = 250;
    localparam int           SCRIPT_LEN       = 29;
    localparam int           PHASE_COUNT      = 6;

    typedef struct packed {
        sva_pkg::vidx_t chosen;
        sva_pkg::kind_t kind;
        logic [7:0]     mask;
    } alloc_result_t;

    typedef struct packed {
        bit             cfg;
        bit             mono;
        sva_pkg::op_t   op;
        sva_pkg::note_t note;
        sva_pkg::vidx_t voice;
        sva_pkg::ring_t ring;
        bit             typed;
        sva_pkg::vidx_t exp_voice;
        sva_pkg::kind_t exp_kind;
        logic [7:0]     exp_mask;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b1, 1'b0, sva_pkg::OP_NOTE_ON,    7'd0,   3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd0,   3'd0, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_FREE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd127, 3'd7, 16'hFFFF,
          1'b1, 3'd1, sva_pkg::KIND_FREE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_OFF,   7'd127, 3'd0, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h02},
        '{1'b0, 1'b0, sva_pkg::OP_SET_RING,   7'd0,   3'd1, 16'hFFFF,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_SET_RING,   7'd0,   3'd7, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_VOICE_DONE, 7'd0,   3'd0, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, OP_RSVD_FIRST,          7'd127, 3'd7, 16'hFFFF,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, OP_RSVD_LAST,           7'd0,   3'd0, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd60,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd60,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd64,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd67,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd0,   3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd127, 3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd60,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd72,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd48,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_OFF,   7'd60,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_SET_RING,   7'd0,   3'd3, 16'h1234,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_SET_RING,   7'd0,   3'd0, 16'h1234,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd50,  3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_VOICE_DONE, 7'd0,   3'd3, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_ALL_OFF,    7'd0,   3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b1, 1'b1, sva_pkg::OP_NOTE_ON,    7'd0,   3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd99,  3'd5, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_ON,    7'd0,   3'd0, 16'h0000,
          1'b1, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b0, 1'b0, sva_pkg::OP_NOTE_OFF,   7'd0,   3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00},
        '{1'b1, 1'b0, sva_pkg::OP_NOTE_ON,    7'd0,   3'd0, 16'h0000,
          1'b0, 3'd0, sva_pkg::KIND_NONE, 8'h00}
    };

    localparam bit PHASE_MONO [PHASE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [6:0]  s_note;
    logic [2:0]  s_voice;
    logic [15:0] s_ring_level;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_chosen_voice;
    logic [1:0]  m_take_kind;
    logic [7:0]  m_released_mask;

    // Allocator shadow state
    bit         mono_setting;
    bit         slot_used  [sva_pkg::VOICE_COUNT];
    bit         slot_gated [sva_pkg::VOICE_COUNT];
    bit [6:0]   slot_note  [sva_pkg::VOICE_COUNT];
    bit [31:0]  slot_stamp [sva_pkg::VOICE_COUNT];
    bit [15:0]  slot_ring  [sva_pkg::VOICE_COUNT];
    bit [31:0]  stamp_count;

    alloc_result_t pending_results [$];
    int            mismatch_count;
    bit            no_idling;
    bit            hold_results;
    bit [6:0]      recent_notes [8];
    logic [2:0]    recent_wr;

    synth_voice_allocator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_note          (s_note),
        .s_voice         (s_voice),
        .s_ring_level    (s_ring_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_voice  (m_chosen_voice),
        .m_take_kind     (m_take_kind),
        .m_released_mask (m_released_mask)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic alloc_result_t predict_alloc(sva_pkg::op_t op,
                                                    sva_pkg::note_t note,
                                                    sva_pkg::vidx_t voice,
                                                    sva_pkg::ring_t ring);
        alloc_result_t res;
        int            best;
        bit            free_hit;
        bit            quiet_hit;
        res       = '{chosen: '0, kind: sva_pkg::KIND_NONE, mask: '0};
        best      = 0;
        free_hit  = 1'b0;
        quiet_hit = 1'b0;
        case (op)
            sva_pkg::OP_NOTE_ON: begin
                if (!mono_setting) begin
                    for (int i = 0; i < sva_pkg::VOICE_COUNT; i++) begin
                        if (!free_hit && !slot_used[i]) begin
                            best     = i;
                            free_hit = 1'b1;
                        end
                    end
                    if (free_hit) begin
                        res.kind = sva_pkg::KIND_FREE;
                    end else begin
                        for (int i = 0; i < sva_pkg::VOICE_COUNT; i++) begin
                            if (!slot_gated[i]
                                    && (!quiet_hit || slot_ring[i] < slot_ring[best])) begin
                                best      = i;
                                quiet_hit = 1'b1;
                            end
                        end
                        if (quiet_hit) begin
                            res.kind = sva_pkg::KIND_QUIET;
                        end else begin
                            best = 0;
                            for (int i = 1; i < sva_pkg::VOICE_COUNT; i++) begin
                                if (slot_stamp[i] < slot_stamp[best]) begin
                                    best = i;
                                end
                            end
                            res.kind = sva_pkg::KIND_OLDEST;
                        end
                    end
                end
                res.chosen        = sva_pkg::vidx_t'(best);
                slot_used[best]   = 1'b1;
                slot_gated[best]  = 1'b1;
                slot_note[best]   = note;
                stamp_count       = stamp_count + 32'd1;
                slot_stamp[best]  = stamp_count;
                slot_ring[best]   = '0;
            end
            sva_pkg::OP_NOTE_OFF: begin
                for (int i = 0; i < sva_pkg::VOICE_COUNT; i++) begin
                    if (slot_used[i] && slot_gated[i] && slot_note[i] == note) begin
                        slot_gated[i] = 1'b0;
                        if (i < 8) begin
                            res.mask[i] = 1'b1;
                        end
                    end
                end
            end
            sva_pkg::OP_SET_RING: begin
                if (int'(voice) < sva_pkg::VOICE_COUNT) begin
                    slot_ring[voice] = ring;
                end
            end
            sva_pkg::OP_VOICE_DONE: begin
                if (int'(voice) < sva_pkg::VOICE_COUNT) begin
                    slot_used[voice]  = 1'b0;
                    slot_gated[voice] = 1'b0;
                end
            end
            sva_pkg::OP_ALL_OFF: begin
                for (int i = 0; i < sva_pkg::VOICE_COUNT; i++) begin
                    if (slot_used[i]) begin
                        if (slot_gated[i] && i < 8) begin
                            res.mask[i] = 1'b1;
                        end
                        slot_gated[i] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Drop valid, drain all results, then write mono_mode over the register port.
    task automatic write_mono(input bit value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sva_pkg::REG_MONO_MODE, 2'b00};
        pwdata  <= {31'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mono_setting = value;
    endtask

    task automatic send_request(input sva_pkg::op_t op, input sva_pkg::note_t note,
                                input sva_pkg::vidx_t voice, input sva_pkg::ring_t ring,
                                input bit typed, input alloc_result_t typed_res);
        alloc_result_t predicted;
        if (!no_idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_note       <= note;
        s_voice      <= voice;
        s_ring_level <= ring;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = predict_alloc(op, note, voice, ring);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pick_request(output sva_pkg::op_t op, output sva_pkg::note_t note,
                                output sva_pkg::vidx_t voice, output sva_pkg::ring_t ring);
        int sel;
        sel   = $urandom_range(0, 99);
        voice = sva_pkg::vidx_t'($urandom);
        note  = ($urandom_range(0, 3) == 0) ? sva_pkg::note_t'($urandom)
                                            : recent_notes[$urandom_range(0, 7)];
        case ($urandom_range(0, 3))
            0:       ring = '0;
            1:       ring = '1;
            2:       ring = sva_pkg::ring_t'($urandom_range(0, 3)) << 14;
            default: ring = sva_pkg::ring_t'($urandom);
        endcase
        if (sel < 38) begin
            op = sva_pkg::OP_NOTE_ON;
            note = sva_pkg::note_t'($urandom);
            recent_notes[recent_wr] = note;
            recent_wr = recent_wr + 3'd1;
        end else if (sel < 58) begin
            op = sva_pkg::OP_NOTE_OFF;
        end else if (sel < 78) begin
            op = sva_pkg::OP_SET_RING;
        end else if (sel < 90) begin
            op = sva_pkg::OP_VOICE_DONE;
        end else if (sel < 96) begin
            op = sva_pkg::OP_ALL_OFF;
        end else begin
            op = sva_pkg::op_t'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end
    endtask

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: expected no result, got voice %0d kind %0d mask %02h",
                         $time, m_chosen_voice, m_take_kind, m_released_mask);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if ({m_chosen_voice, m_take_kind, m_released_mask} !== want) begin
                    $display({"%0t: expected voice %0d kind %0d mask %02h, ",
                              "got voice %0d kind %0d mask %02h"},
                             $time, want.chosen, want.kind, want.mask,
                             m_chosen_voice, m_take_kind, m_released_mask);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else if (!no_idling && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("synth_voice_allocator_tb: FAIL");
        $finish;
    end

    initial begin
        sva_pkg::op_t   op;
        sva_pkg::note_t note;
        sva_pkg::vidx_t voice;
        sva_pkg::ring_t ring;
        alloc_result_t  typed_res;
        int             item_count;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_op           = '0;
        s_note         = '0;
        s_voice        = '0;
        s_ring_level   = '0;
        mismatch_count = 0;
        no_idling      = 1'b0;
        hold_results   = 1'b0;
        recent_wr      = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (SCRIPT[r].cfg) begin
                write_mono(SCRIPT[r].mono);
            end else begin
                typed_res = '{chosen: SCRIPT[r].exp_voice, kind: SCRIPT[r].exp_kind,
                              mask: SCRIPT[r].exp_mask};
                send_request(SCRIPT[r].op, SCRIPT[r].note, SCRIPT[r].voice, SCRIPT[r].ring,
                             SCRIPT[r].typed, typed_res);
            end
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_mono(PHASE_MONO[ph]);
            no_idling    = (ph == PHASE_COUNT - 1);
            hold_results = (ph == 2);
            item_count   = PHASE_MONO[ph] ? 150 : 240;
            repeat (item_count) begin
                pick_request(op, note, voice, ring);
                send_request(op, note, voice, ring, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (sva_pkg::VOICE_COUNT + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("synth_voice_allocator_tb: PASS");
        end else begin
            $display("synth_voice_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule

### synth_voice_allocator.f
+incdir+rtl
rtl/sva_pkg.sv
rtl/synth_voice_allocator.sv
tb/synth_voice_allocator_tb.sv
